// File: hdl/hcbw_pkg.sv
// Shared types, constants, tables and helper functions for the child boundary edge walker.
package hcbw_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [4:0] MAX_RES_C   = 5'd15;
  localparam int         RES_LSB     = 52;
  localparam int         DIR_LSB     = 56;
  localparam int         MODE_LSB    = 59;
  localparam logic [3:0] MODE_EDGE   = 4'd2;
  localparam logic [4:0] POS_MOD     = 5'd18;
  localparam logic [4:0] POS_BACK    = 5'd13;
  localparam logic [4:0] POS_FWD     = 5'd1;
  localparam logic [4:0] POS_FIRST   = 5'd0;
  localparam logic [4:0] POS_ODD     = 5'd14;
  localparam logic [4:0] POS_EVEN    = 5'd16;
  localparam logic [2:0] DIGIT_SKIP  = 3'd1;
  localparam logic [2:0] DIR_SKIP    = 3'd1;
  localparam logic [2:0] EP_LAST     = 3'd5;

  localparam logic [2:0] SIDE_DIGIT_TBL [18] = '{
    3'd1, 3'd1, 3'd1, 3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd4,
    3'd6, 3'd6, 3'd6, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3
  };

  localparam logic [2:0] EDGE_DIRS_TBL [6] = '{3'd3, 3'd1, 3'd5, 3'd4, 3'd6, 3'd2};

  localparam logic [1:0] MOD3_TBL [18] = '{
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2
  };

  typedef struct packed {
    logic        accept;
    logic        opcode;
    logic [63:0] cell_idx;
    logic [3:0]  child;
    logic        pent;
    logic        out_free;
  } seq_ctl_t;

  typedef struct packed {
    logic idle;
    logic load;
  } seq_stat_t;

  typedef struct packed {
    logic [4:0] pos_nxt;
    logic [2:0] digit;
    logic [1:0] mod3;
  } lvl_res_t;

  function automatic logic [5:0] digit_shift(input logic [3:0] lvl);
    logic [3:0] inv;
    inv = ~lvl;
    return {1'b0, inv, 1'b0} + {2'b00, inv};
  endfunction

  function automatic logic [2:0] ep_inc(input logic [2:0] ep);
    return (ep == EP_LAST) ? 3'd0 : ep + 3'd1;
  endfunction

  function automatic logic [2:0] ep_dec(input logic [2:0] ep);
    return (ep == 3'd0) ? EP_LAST : ep - 3'd1;
  endfunction

endpackage

// File: hdl/hcbw_level_unit.sv
// Shared per-level unit: walk position advance, side digit lookup and position mod 3.
module hcbw_level_unit (
  input  logic [4:0]          pos,
  input  logic                back,
  output hcbw_pkg::lvl_res_t  res
);
  import hcbw_pkg::*;

  logic [4:0] sum;

  assign sum         = pos + (back ? POS_BACK : POS_FWD);
  assign res.pos_nxt = (sum >= POS_MOD) ? sum - POS_MOD : sum;
  assign res.digit   = SIDE_DIGIT_TBL[res.pos_nxt];
  assign res.mod3    = MOD3_TBL[pos];

endmodule

// File: hdl/hcbw_seq.sv
// Walk state and the sequencer that steps the shared level unit over the levels.
module hcbw_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  hcbw_pkg::seq_ctl_t  ctl,
  output hcbw_pkg::seq_stat_t stat,
  output logic [63:0]         cur_edge
);
  import hcbw_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_INIT   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_WALK   = 7'b0001000,
    S_EDGE   = 7'b0010000,
    S_CHECK  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t      st_r, st_nxt;
  logic [63:0] cur_r, cur_nxt;
  logic [27:0] left_r, left_nxt;
  logic [4:0]  lwp_r [16];
  logic [2:0]  ep_r, ep_nxt;
  logic [3:0]  par_r, par_nxt;
  logic [3:0]  fin_r, fin_nxt;
  logic [3:0]  lvl_r, lvl_nxt;
  logic        pent_r, pent_nxt;
  logic        chg_r, chg_nxt;
  logic        lwp_we, lwp_clr;
  logic [4:0]  lwp_wd;
  logic [4:0]  init_pos;
  logic [5:0]  dsh, psh;
  logic [3:0]  par1, par_in;
  logic [2:0]  ep_sel, ep_d0, ep_d0a;
  lvl_res_t    lu;

  hcbw_level_unit u_level (
    .pos  (lwp_r[lvl_r]),
    .back (chg_r),
    .res  (lu)
  );

  assign par1     = par_r + 4'd1;
  assign par_in   = ctl.cell_idx[RES_LSB +: 4];
  assign dsh      = digit_shift(lvl_r);
  assign psh      = digit_shift(par1);
  assign init_pos = (lvl_r == par1) ? POS_FIRST : (lvl_r[0] ? POS_ODD : POS_EVEN);
  assign ep_d0a   = ep_inc(ep_r);
  assign ep_d0    = (pent_r && EDGE_DIRS_TBL[ep_d0a] == DIR_SKIP) ? ep_inc(ep_d0a) : ep_d0a;
  assign ep_sel   = chg_r ? ep_dec(ep_r) : ep_inc(ep_r);
  assign cur_edge = cur_r;
  assign stat.idle = (st_r == S_IDLE);
  assign stat.load = (st_r == S_FINISH) && ctl.out_free;

  always_comb begin
    st_nxt   = st_r;
    cur_nxt  = cur_r;
    left_nxt = left_r;
    ep_nxt   = ep_r;
    par_nxt  = par_r;
    fin_nxt  = fin_r;
    lvl_nxt  = lvl_r;
    pent_nxt = pent_r;
    chg_nxt  = chg_r;
    lwp_we   = 1'b0;
    lwp_clr  = 1'b0;
    lwp_wd   = lu.pos_nxt;
    unique case (st_r)
      S_IDLE: begin
        if (ctl.accept) begin
          if (ctl.opcode == OP_START) begin
            pent_nxt = ctl.pent;
            if (ctl.child < par_in || {1'b0, ctl.child} > MAX_RES_C) begin
              cur_nxt  = '0;
              left_nxt = '0;
              st_nxt   = S_FINISH;
            end else begin
              par_nxt                   = par_in;
              fin_nxt                   = ctl.child;
              cur_nxt                   = ctl.cell_idx;
              cur_nxt[RES_LSB +: 4]     = ctl.child;
              cur_nxt[MODE_LSB +: 4]    = MODE_EDGE;
              cur_nxt[DIR_LSB +: 3]     = EDGE_DIRS_TBL[0];
              ep_nxt                    = 3'd0;
              lwp_clr                   = 1'b1;
              left_nxt                  = ctl.pent ? 28'd5 : 28'd6;
              lvl_nxt                   = par_in + 4'd1;
              st_nxt                    = (par_in == ctl.child) ? S_FINISH : S_INIT;
            end
          end else if (cur_r == '0) begin
            st_nxt = S_FINISH;
          end else if (left_r <= 28'd1) begin
            left_nxt = '0;
            cur_nxt  = '0;
            st_nxt   = S_FINISH;
          end else begin
            left_nxt = left_r - 28'd1;
            if (par_r == fin_r) begin
              ep_nxt                = ep_d0;
              cur_nxt[DIR_LSB +: 3] = EDGE_DIRS_TBL[ep_d0];
              st_nxt                = S_FINISH;
            end else begin
              lvl_nxt = fin_r;
              st_nxt  = S_SCAN;
            end
          end
        end
      end
      S_INIT: begin
        lwp_we           = 1'b1;
        lwp_wd           = init_pos;
        cur_nxt[dsh +: 3] = SIDE_DIGIT_TBL[init_pos];
        left_nxt         = left_r + {left_r[26:0], 1'b0};
        if (lvl_r == fin_r) begin
          st_nxt = S_CHECK;
        end else begin
          lvl_nxt = lvl_r + 4'd1;
        end
      end
      S_SCAN: begin
        if (lvl_r > par1 && lu.mod3 == {1'b0, lvl_r[0]}) begin
          lvl_nxt = lvl_r - 4'd1;
        end else begin
          chg_nxt = 1'b0;
          st_nxt  = S_WALK;
        end
      end
      S_WALK: begin
        lwp_we            = 1'b1;
        cur_nxt[dsh +: 3] = lu.digit;
        chg_nxt           = (lu.digit != cur_r[dsh +: 3]);
        if (lvl_r == fin_r) begin
          st_nxt = S_EDGE;
        end else begin
          lvl_nxt = lvl_r + 4'd1;
        end
      end
      S_EDGE: begin
        ep_nxt                = ep_sel;
        cur_nxt[DIR_LSB +: 3] = EDGE_DIRS_TBL[ep_sel];
        st_nxt                = S_CHECK;
      end
      S_CHECK: begin
        if (pent_r && cur_r[psh +: 3] == DIGIT_SKIP) begin
          lvl_nxt = fin_r;
          st_nxt  = S_SCAN;
        end else begin
          st_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (ctl.out_free) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      cur_r  <= '0;
      left_r <= '0;
      ep_r   <= '0;
      par_r  <= '0;
      fin_r  <= '0;
      lvl_r  <= '0;
      pent_r <= 1'b0;
      chg_r  <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cur_r  <= cur_nxt;
      left_r <= left_nxt;
      ep_r   <= ep_nxt;
      par_r  <= par_nxt;
      fin_r  <= fin_nxt;
      lvl_r  <= lvl_nxt;
      pent_r <= pent_nxt;
      chg_r  <= chg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || lwp_clr) begin
      for (int i = 0; i < 16; i++) begin
        lwp_r[i] <= '0;
      end
    end else if (lwp_we) begin
      lwp_r[lvl_r] <= lwp_wd;
    end
  end

  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SCAN || st_r == S_WALK) |-> (lvl_r <= fin_r && lvl_r > par_r))
    else $error("Level counter left the walked range.");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SCAN || st_r == S_WALK) |-> (lwp_r[lvl_r] < POS_MOD))
    else $error("Walk position out of range.");

  a_ep_range: assert property (@(posedge clk) disable iff (!rst_n)
    ep_r <= EP_LAST)
    else $error("Edge position out of range.");

  a_walk_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_WALK || st_r == S_EDGE) |-> (cur_r[MODE_LSB +: 4] == MODE_EDGE))
    else $error("Edge mode lost during an advance.");

endmodule

// File: hdl/hex_child_boundary_edge_walker.sv
// Top level of the child boundary edge walker: handshakes and result register.
//
//  Channel | Direction | Handshake            | Payload
//  in_     | input     | in_valid / in_ready   | opcode, cell_index, child_resolution, pentagon_flag
//  out_    | output    | out_valid / out_ready | edge_index, walk_done
//
// One item at a time; in_ready is high only while the sequencer is idle.
// Start: at delta 0 nothing is walked; otherwise each child level gets its first digit in
// turn, plus pentagon skips. Step: at delta 0 only the edge direction moves on; otherwise
// each advance goes through the shared level unit, one more for every skipped pentagon edge.
// Reset clears the walk; a result waits in the output register while the next item is taken,
// and the sequencer holds in its last state while that register is still full.
module hex_child_boundary_edge_walker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [63:0] in_cell_index,
  input  logic [3:0]  in_child_resolution,
  input  logic        in_pentagon_flag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_edge_index,
  output logic        out_walk_done
);
  import hcbw_pkg::*;

  seq_ctl_t    ctl;
  seq_stat_t   stat;
  logic [63:0] cur_edge;
  logic        out_valid_r;
  logic [63:0] out_edge_r;
  logic        out_done_r;

  assign in_ready     = stat.idle;
  assign ctl.accept   = in_valid && in_ready;
  assign ctl.opcode   = in_opcode;
  assign ctl.cell_idx = in_cell_index;
  assign ctl.child    = in_child_resolution;
  assign ctl.pent     = in_pentagon_flag;
  assign ctl.out_free = !out_valid_r || out_ready;

  hcbw_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .stat     (stat),
    .cur_edge (cur_edge)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.load) begin
      out_edge_r <= cur_edge;
      out_done_r <= (cur_edge == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_edge_index = out_edge_r;
  assign out_walk_done  = out_done_r;

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("Input taken again before the result was produced.");

  a_done_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_done_r == (out_edge_r == '0)))
    else $error("Done flag disagrees with edge index.");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    stat.load |=> out_valid_r)
    else $error("Loaded result not presented.");

endmodule

// File: sim/hcbw_edge_checker.sv
// Checker for the child boundary edge walker: predicts each result from the input transfers.
`timescale 1ns / 100ps

module hcbw_edge_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_opcode,
  input  logic [63:0] in_cell_index,
  input  logic [3:0]  in_child_resolution,
  input  logic        in_pentagon_flag,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_edge_index,
  input  logic        out_walk_done,
  output int          fail_count,
  output int          pending
);
  import hcbw_pkg::*;

  localparam logic [3:0] EDGE_MODE = 4'd2;
  localparam logic [2:0] SKIPPED_DIGIT = 3'd1;
  localparam logic [2:0] SKIPPED_DIR = 3'd1;

  typedef struct packed {
    logic [63:0] edge_idx;
    logic        done;
  } edge_rec_t;

  edge_rec_t expected_edges[$];

  logic [63:0] walk_edge;
  logic [27:0] edges_rem;
  logic [4:0]  lvl_pos [16];
  logic [2:0]  dir_pos;
  logic [3:0]  par_res;
  logic [3:0]  fin_res;
  logic        pent_mode;

  // Digit visited at each of the 18 walk positions of one level.
  function automatic logic [2:0] side_digit(input int p);
    case (p / 3)
      0: return 3'd1;
      1: return 3'd5;
      2: return 3'd4;
      3: return 3'd6;
      4: return 3'd2;
      default: return 3'd3;
    endcase
  endfunction

  function automatic logic [2:0] dir_code(input int p);
    case (p)
      0: return 3'd3;
      1: return 3'd1;
      2: return 3'd5;
      3: return 3'd4;
      4: return 3'd6;
      default: return 3'd2;
    endcase
  endfunction

  function automatic logic [2:0] digit_of(input int r);
    return walk_edge[3 * (15 - r) +: 3];
  endfunction

  function automatic void put_digit(input int r, input logic [2:0] d);
    walk_edge[3 * (15 - r) +: 3] = d;
  endfunction

  function automatic bit step_cells();
    int lo;
    int l;
    int p;
    bit changed;
    logic [2:0] prev;
    logic [2:0] d;
    lo = fin_res;
    while (lo > par_res + 1 && (lvl_pos[lo] % 3) == (lo & 1))
      lo--;
    changed = 1'b0;
    for (l = lo; l <= fin_res; l++) begin
      p = lvl_pos[l];
      prev = digit_of(l);
      if (l > lo && changed)
        p = (p + 12) % 18;
      p = (p + 1) % 18;
      lvl_pos[l] = p[4:0];
      d = side_digit(p);
      put_digit(l, d);
      changed = (d != prev);
    end
    return changed;
  endfunction

  function automatic void step_edge();
    bit moved;
    int p;
    moved = step_cells();
    p = moved ? (dir_pos + 5) % 6 : (dir_pos + 1) % 6;
    dir_pos = p[2:0];
    walk_edge[58:56] = dir_code(p);
  endfunction

  function automatic void skip_pentagon_side();
    int lvl;
    lvl = par_res + 1;
    while (pent_mode && walk_edge != 64'd0 && digit_of(lvl) == SKIPPED_DIGIT)
      step_edge();
  endfunction

  function automatic edge_rec_t predict_edge(input logic op, input logic [63:0] cell_word,
                                             input logic [3:0] child, input logic pent);
    edge_rec_t rec;
    int par;
    int r;
    int p;
    int unsigned cnt;
    if (op == OP_START) begin
      par = cell_word[55:52];
      pent_mode = pent;
      if (child < par) begin
        walk_edge = '0;
        edges_rem = '0;
      end else begin
        par_res = par[3:0];
        fin_res = child;
        walk_edge = cell_word;
        dir_pos = '0;
        foreach (lvl_pos[i]) lvl_pos[i] = '0;
        cnt = pent ? 5 : 6;
        for (r = par; r < child; r++)
          cnt = cnt * 3;
        edges_rem = cnt[27:0];
        if (par != child) begin
          walk_edge[55:52] = child;
          for (r = par + 1; r <= child; r++) begin
            p = (r == par + 1) ? 0 : ((r & 1) ? 14 : 16);
            lvl_pos[r] = p[4:0];
            put_digit(r, side_digit(p));
          end
        end
        walk_edge[62:59] = EDGE_MODE;
        walk_edge[58:56] = dir_code(0);
        if (par != child)
          skip_pentagon_side();
      end
    end else if (walk_edge != 64'd0) begin
      if (edges_rem <= 1) begin
        edges_rem = '0;
        walk_edge = '0;
      end else begin
        edges_rem = edges_rem - 1;
        if (par_res == fin_res) begin
          p = (dir_pos + 1) % 6;
          if (pent_mode && dir_code(p) == SKIPPED_DIR)
            p = (p + 1) % 6;
          dir_pos = p[2:0];
          walk_edge[58:56] = dir_code(p);
        end else begin
          step_edge();
          skip_pentagon_side();
        end
      end
    end
    rec.edge_idx = walk_edge;
    rec.done = (walk_edge == 64'd0);
    return rec;
  endfunction

  always @(posedge clk) begin : track
    edge_rec_t want;
    if (!rst_n) begin
      walk_edge = '0;
      edges_rem = '0;
      foreach (lvl_pos[i]) lvl_pos[i] = '0;
      dir_pos = '0;
      par_res = '0;
      fin_res = '0;
      pent_mode = 1'b0;
      expected_edges.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_edges.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result transfer edge %h done %b",
                     $realtime, out_edge_index, out_walk_done);
        end else begin
          want = expected_edges.pop_front();
          if (out_edge_index !== want.edge_idx || out_walk_done !== want.done) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: expected edge %h done %b, got edge %h done %b", $realtime,
                       want.edge_idx, want.done, out_edge_index, out_walk_done);
          end
        end
      end
      if (in_valid && in_ready)
        expected_edges.push_back(predict_edge(in_opcode, in_cell_index,
                                              in_child_resolution, in_pentagon_flag));
    end
    pending = expected_edges.size();
  end

endmodule

// File: sim/tb_hex_child_boundary_edge_walker.sv
// Testbench top for the child boundary edge walker: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_hex_child_boundary_edge_walker;
  import hcbw_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int TAIL_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  logic [63:0] in_cell_index;
  logic [3:0]  in_child_resolution;
  logic        in_pentagon_flag;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_edge_index;
  logic        out_walk_done;

  int fail_count;
  int pending;
  int items_sent;
  int hold_cycles;
  int cycle_count = 0;
  bit calm;

  hex_child_boundary_edge_walker uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_cell_index       (in_cell_index),
    .in_child_resolution (in_child_resolution),
    .in_pentagon_flag    (in_pentagon_flag),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_edge_index      (out_edge_index),
    .out_walk_done       (out_walk_done)
  );

  hcbw_edge_checker edge_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_cell_index       (in_cell_index),
    .in_child_resolution (in_child_resolution),
    .in_pentagon_flag    (in_pentagon_flag),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_edge_index      (out_edge_index),
    .out_walk_done       (out_walk_done),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[hex_child_boundary_edge_walker] ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] cell_at(input int res);
    logic [63:0] c;
    c = {$urandom, $urandom};
    c[55:52] = res[3:0];
    return c;
  endfunction

  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          stall--;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic offer(input logic op, input logic [63:0] cell_word, input logic [3:0] child,
                       input logic pent);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_cell_index <= cell_word;
    in_child_resolution <= child;
    in_pentagon_flag <= pent;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic step_item();
    offer(OP_STEP, {$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    int target;
    int sel;
    int par;
    int cap;
    int delta;
    int total;
    int n;
    bit pent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_START;
    in_cell_index = '0;
    in_child_resolution = '0;
    in_pentagon_flag = 1'b0;
    items_sent = 0;
    hold_cycles = 0;
    calm = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    step_item();
    offer(OP_START, cell_at(15), 4'd15, 1'b0);
    repeat (6) step_item();
    offer(OP_START, cell_at(15), 4'd15, 1'b1);
    repeat (5) step_item();
    offer(OP_START, cell_at(9), 4'd3, 1'b0);
    offer(OP_START, 64'd0, 4'd0, 1'b0);
    step_item();
    offer(OP_START, '1, 4'd15, 1'b0);
    step_item();
    offer(OP_START, 64'd0, 4'd15, 1'b0);
    repeat (2) step_item();
    offer(OP_START, cell_at(5), 4'd6, 1'b1);
    repeat (3) step_item();
    wait_drain();

    hold_cycles = 300;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      sel = $urandom_range(0, 99);
      calm = ($urandom_range(0, 5) == 0);
      if (sel < 4) begin
        step_item();
      end else if (sel < 9) begin
        par = $urandom_range(1, 15);
        offer(OP_START, cell_at(par), 4'($urandom_range(0, par - 1)),
              1'($urandom_range(0, 1)));
      end else if (sel < 12) begin
        hold_cycles = $urandom_range(150, 400);
      end else if (sel < 15) begin
        wait_drain();
      end else begin
        pent = ($urandom_range(0, 2) == 0);
        par = $urandom_range(0, 15);
        cap = 15 - par;
        if (pent && cap > 4)
          cap = 4;
        if ($urandom_range(0, 9) == 0)
          delta = $urandom_range(0, cap);
        else
          delta = $urandom_range(0, (cap < 3) ? cap : 3);
        offer(OP_START, cell_at(par), 4'(par + delta), pent);
        total = pent ? 5 : 6;
        repeat (delta) total = total * 3;
        if (total <= 60 && $urandom_range(0, 1) == 1)
          n = total + $urandom_range(0, 2);
        else
          n = $urandom_range(1, 24);
        repeat (n) step_item();
      end
    end
    calm = 1'b0;

    wait_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[hex_child_boundary_edge_walker] OK");
    else
      $display("[hex_child_boundary_edge_walker] ERROR");
    $finish;
  end

endmodule
